// File: src/lzfb_pkg.sv
`timescale 1ns / 1ps

package lzfb_pkg;

   localparam int unsigned COUNT_WIDTH = 24;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 24'hFF_FFFF;

   localparam logic OP_FEED  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [2:0] COPY_BASE    = 3'd3;
   localparam logic [2:0] COPY_EXTEND  = 3'd6;
   localparam logic [7:0] EXT_CONTINUE = 8'd255;
   localparam logic [7:0] DIST_HI_MASK = 8'h3F;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       accepted;
      logic       copy_pending;
      logic       frame_done;
   } rsp_type;

   // one classified request, handed from the parser to the history stage
   typedef struct packed {
      logic       out_valid;
      logic       from_history;
      logic       zero_fill;
      logic [7:0] data_byte;
      logic       accepted;
      logic       copy_pending;
      logic       frame_done;
   } cmd_type;

endpackage

// File: src/lzfb_ram.sv
`timescale 1ns / 1ps

module lzfb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and a write to the same address return the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lzfb_fifo.sv
`timescale 1ns / 1ps

module lzfb_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/lzfb_front.sv
`timescale 1ns / 1ps

module lzfb_front #(
   parameter int unsigned WINDOW_DEPTH = 16384,
   parameter int unsigned HEADER_BYTES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lzfb_pkg::req_type               req_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lzfb_pkg::COUNT_WIDTH-1:0] csr_data,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output lzfb_pkg::cmd_type               cmd_data,
   output logic [$clog2(WINDOW_DEPTH)-1:0] cmd_rd_idx,
   output logic [$clog2(WINDOW_DEPTH)-1:0] cmd_wr_idx
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam int unsigned HW = $clog2(HEADER_BYTES + 2);
   localparam int unsigned NW = lzfb_pkg::COUNT_WIDTH;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_HIGH = 2'd1;
   localparam logic [1:0] PHASE_EXT  = 2'd2;

   logic [NW-1:0] out_length_ff;
   logic [NW-1:0] produced_ff, produced_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [HW-1:0] header_ff, header_in;
   logic [7:0]    flag_ff, flag_in;
   logic [3:0]    bit_pos_ff, bit_pos_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    low_dist_ff, low_dist_in;
   logic [NW-1:0] copy_rem_ff, copy_rem_in;
   logic [14:0]   copy_dist_ff, copy_dist_in;
   logic          ended_ff, ended_in;

   logic          accept;
   logic          done_now;
   logic          pending_now;
   logic          emit;
   logic [AW:0]   rd_diff;
   logic [2:0]    count;
   logic [NW:0]   ext_sum;
   logic [7:0]    b;
   logic          last;
   lzfb_pkg::cmd_type cmd;

   assign req_ready = cmd_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign last      = req_data.last_byte;

   assign done_now    = (produced_ff >= out_length_ff) || (ended_ff && copy_rem_ff == '0);
   assign pending_now = (phase_ff == PHASE_IDLE) && (copy_rem_ff != '0) && !done_now;

   assign rd_diff = (AW+1)'(wr_idx_ff) - (AW+1)'(copy_dist_ff);
   assign count   = 3'(b[7:6]) + lzfb_pkg::COPY_BASE;
   assign ext_sum = (NW+1)'(copy_rem_ff) + (NW+1)'(b);

   always_comb begin
      produced_in  = produced_ff;
      wr_idx_in    = wr_idx_ff;
      header_in    = header_ff;
      flag_in      = flag_ff;
      bit_pos_in   = bit_pos_ff;
      phase_in     = phase_ff;
      low_dist_in  = low_dist_ff;
      copy_rem_in  = copy_rem_ff;
      copy_dist_in = copy_dist_ff;
      ended_in     = ended_ff;
      emit         = 1'b0;
      cmd          = '0;

      if (req_data.opcode == lzfb_pkg::OP_DRAIN) begin
         if (pending_now) begin
            emit             = 1'b1;
            cmd.out_valid    = 1'b1;
            cmd.from_history = 1'b1;
            cmd.zero_fill    = (produced_ff < NW'(copy_dist_ff));
            copy_rem_in      = copy_rem_ff - NW'(1);
         end
      end else if (!done_now && !pending_now) begin
         cmd.accepted = 1'b1;
         if (header_ff != '0) begin
            header_in = header_ff - HW'(1);
         end else if (phase_ff == PHASE_HIGH) begin
            copy_dist_in = {1'b0, b[5:0] & lzfb_pkg::DIST_HI_MASK[5:0], low_dist_ff} + 15'd1;
            copy_rem_in  = NW'(count);
            phase_in     = (count == lzfb_pkg::COPY_EXTEND && !last) ? PHASE_EXT : PHASE_IDLE;
         end else if (phase_ff == PHASE_EXT) begin
            copy_rem_in = ext_sum[NW] ? lzfb_pkg::COUNT_MAX : ext_sum[NW-1:0];
            if (b != lzfb_pkg::EXT_CONTINUE || last) begin
               phase_in = PHASE_IDLE;
            end
         end else if (bit_pos_ff[3]) begin
            flag_in    = b;
            bit_pos_in = '0;
         end else if (!flag_ff[bit_pos_ff[2:0]]) begin
            emit          = 1'b1;
            cmd.out_valid = 1'b1;
            cmd.data_byte = b;
            bit_pos_in    = bit_pos_ff + 4'd1;
         end else begin
            bit_pos_in = bit_pos_ff + 4'd1;
            if (!last) begin
               low_dist_in = b;
               phase_in    = PHASE_HIGH;
            end
         end
         if (last) begin
            ended_in = 1'b1;
         end
      end

      if (emit) begin
         produced_in = produced_ff + NW'(1);
         wr_idx_in   = (wr_idx_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_ff + AW'(1);
      end

      cmd.frame_done   = (produced_in >= out_length_ff) || (ended_in && copy_rem_in == '0);
      cmd.copy_pending = (phase_in == PHASE_IDLE) && (copy_rem_in != '0) && !cmd.frame_done;
   end

   assign cmd_valid  = accept;
   assign cmd_data   = cmd;
   assign cmd_wr_idx = wr_idx_ff;
   assign cmd_rd_idx = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(WINDOW_DEPTH)) : rd_diff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= '0;
         produced_ff   <= '0;
         wr_idx_ff     <= '0;
         header_ff     <= HW'(HEADER_BYTES);
         flag_ff       <= '0;
         bit_pos_ff    <= 4'd8;
         phase_ff      <= PHASE_IDLE;
         low_dist_ff   <= '0;
         copy_rem_ff   <= '0;
         copy_dist_ff  <= '0;
         ended_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            out_length_ff <= csr_data;
         end
         if (accept) begin
            produced_ff  <= produced_in;
            wr_idx_ff    <= wr_idx_in;
            header_ff    <= header_in;
            flag_ff      <= flag_in;
            bit_pos_ff   <= bit_pos_in;
            phase_ff     <= phase_in;
            low_dist_ff  <= low_dist_in;
            copy_rem_ff  <= copy_rem_in;
            copy_dist_ff <= copy_dist_in;
            ended_ff     <= ended_in;
         end
      end
   end

endmodule

// File: src/lzfb_back.sv
`timescale 1ns / 1ps

module lzfb_back #(
   parameter int unsigned WINDOW_DEPTH = 16384,
   parameter int unsigned RSP_DEPTH    = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  lzfb_pkg::cmd_type                 cmd_data,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]   cmd_rd_idx,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]   cmd_wr_idx,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]    rsp_count,
   output logic                              rsp_push_valid,
   output lzfb_pkg::rsp_type                 rsp_push_data
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam int unsigned CW = $clog2(RSP_DEPTH + 1);

   logic              s_valid_ff;
   lzfb_pkg::cmd_type s_cmd_ff;
   logic [AW-1:0]     s_wr_idx_ff;
   logic              s_byp_ff;
   logic [7:0]        s_byp_data_ff;

   logic [CW:0]       in_use;
   logic              take;
   logic [7:0]        ram_rdata;
   logic [7:0]        hist_byte;
   logic [7:0]        out_byte;
   logic              ram_we;

   // a taken request always finds room in the response queue
   assign in_use    = (CW+1)'(rsp_count) + (CW+1)'(s_valid_ff);
   assign cmd_ready = (in_use < (CW+1)'(RSP_DEPTH));
   assign take      = cmd_valid && cmd_ready;

   assign hist_byte = s_byp_ff ? s_byp_data_ff : ram_rdata;

   always_comb begin
      if (!s_cmd_ff.out_valid) begin
         out_byte = 8'h00;
      end else if (!s_cmd_ff.from_history) begin
         out_byte = s_cmd_ff.data_byte;
      end else if (s_cmd_ff.zero_fill) begin
         out_byte = 8'h00;
      end else begin
         out_byte = hist_byte;
      end
   end

   assign ram_we = s_valid_ff && s_cmd_ff.out_valid;

   lzfb_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s_wr_idx_ff),
      .wr_data (out_byte),
      .rd_en   (take),
      .rd_addr (cmd_rd_idx),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= take;
      end
   end

   // byte being written this cycle is not yet visible to the read
   always_ff @(posedge clock) begin
      if (take) begin
         s_cmd_ff      <= cmd_data;
         s_wr_idx_ff   <= cmd_wr_idx;
         s_byp_ff      <= ram_we && (s_wr_idx_ff == cmd_rd_idx);
         s_byp_data_ff <= out_byte;
      end
   end

   assign rsp_push_valid             = s_valid_ff;
   assign rsp_push_data.out_valid    = s_cmd_ff.out_valid;
   assign rsp_push_data.out_byte     = out_byte;
   assign rsp_push_data.accepted     = s_cmd_ff.accepted;
   assign rsp_push_data.copy_pending = s_cmd_ff.copy_pending;
   assign rsp_push_data.frame_done   = s_cmd_ff.frame_done;

endmodule

// File: src/lz_flag_byte_decompressor.sv
`timescale 1ns / 1ps

// channel  direction  payload                        handshake
// req      in         lzfb_pkg::req_type req_data    req_valid / req_ready
// rsp      out        lzfb_pkg::rsp_type rsp_data    rsp_valid / rsp_ready
// csr      in         out_length, 24 bit csr_data    csr_valid / csr_ready
//
// One request per cycle while req_ready stays high; each request gives one response, passing
// through the parser, the command queue and the history read stage.
// History RAM: one write and one read port; a copy byte written in the cycle of a dependent
// read is forwarded around the RAM. Synchronous active-high reset clears control state only.
// req_ready drops when the command queue is full; the history stage stops taking commands
// while the response queue lacks room.

module lz_flag_byte_decompressor #(
   parameter int unsigned WINDOW_DEPTH = 16384,
   parameter int unsigned HEADER_BYTES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lzfb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lzfb_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lzfb_pkg::COUNT_WIDTH-1:0] csr_data
);

   localparam int unsigned AW        = $clog2(WINDOW_DEPTH);
   localparam int unsigned CMD_DEPTH = 2;
   localparam int unsigned CCW       = $clog2(CMD_DEPTH + 1);
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned CMD_W     = $bits(lzfb_pkg::cmd_type) + 2 * AW;
   localparam int unsigned RSP_W     = $bits(lzfb_pkg::rsp_type);

   logic                            fr_cmd_valid;
   logic                            fr_cmd_ready;
   lzfb_pkg::cmd_type               fr_cmd_data;
   logic [AW-1:0]                   fr_rd_idx;
   logic [AW-1:0]                   fr_wr_idx;

   logic                            q_cmd_valid;
   logic                            q_cmd_ready;
   logic [CMD_W-1:0]                q_cmd_bits;
   lzfb_pkg::cmd_type               q_cmd_data;
   logic [AW-1:0]                   q_rd_idx;
   logic [AW-1:0]                   q_wr_idx;
   logic [CCW-1:0]                  cmd_count;

   logic                            bk_push_valid;
   lzfb_pkg::rsp_type               bk_push_data;
   logic                            rsp_push_ready;
   logic [$clog2(RSP_DEPTH+1)-1:0]  rsp_count;
   logic [RSP_W-1:0]                rsp_bits;

   lzfb_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd_valid  (fr_cmd_valid),
      .cmd_ready  (fr_cmd_ready),
      .cmd_data   (fr_cmd_data),
      .cmd_rd_idx (fr_rd_idx),
      .cmd_wr_idx (fr_wr_idx)
   );

   lzfb_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_cmd_valid),
      .push_ready (fr_cmd_ready),
      .push_data  ({fr_rd_idx, fr_wr_idx, fr_cmd_data}),
      .pop_valid  (q_cmd_valid),
      .pop_ready  (q_cmd_ready),
      .pop_data   (q_cmd_bits),
      .count      (cmd_count)
   );

   assign {q_rd_idx, q_wr_idx, q_cmd_data} = q_cmd_bits;

   lzfb_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .RSP_DEPTH    (RSP_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_cmd_valid),
      .cmd_ready      (q_cmd_ready),
      .cmd_data       (q_cmd_data),
      .cmd_rd_idx     (q_rd_idx),
      .cmd_wr_idx     (q_wr_idx),
      .rsp_count      (rsp_count),
      .rsp_push_valid (bk_push_valid),
      .rsp_push_data  (bk_push_data)
   );

   lzfb_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (bk_push_valid),
      .push_ready (rsp_push_ready),
      .push_data  (bk_push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_bits),
      .count      (rsp_count)
   );

   assign rsp_data = rsp_bits;

`ifndef SYNTHESIS
   a_rsp_no_overflow : assert property (@(posedge clock) disable iff (reset)
      bk_push_valid |-> rsp_push_ready)
      else $error("response queue overflow");

   a_pending_not_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.copy_pending && rsp_data.frame_done))
      else $error("copy pending on a finished frame");

   a_idle_byte_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_byte == 8'h00)
      else $error("byte without out_valid");

   a_drain_not_accepted : assert property (@(posedge clock) disable iff (reset)
      q_cmd_valid && q_cmd_data.from_history |-> !q_cmd_data.accepted)
      else $error("copy byte marked as accepted feed");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> cmd_count == CCW'(CMD_DEPTH))
      else $error("request stalled with room in the command queue");
`endif

endmodule
